@@ hdl/lubs_pkg.sv @@
`default_nettype none

package lubs_pkg;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_FAIL    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_HOST = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic REG_HOST_COUNT   = 1'b0;
  localparam logic REG_RETRY        = 1'b1;

  localparam logic [3:0]  HOST_COUNT_RESET = 4'd1;
  localparam logic [15:0] RETRY_RESET      = 16'd60;
  localparam logic [15:0] USAGE_MAX        = 16'hFFFF;
  localparam int          INDEX_LIMIT      = 8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  host_index;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chosen_index;
    logic [15:0] usage_after;
  } rsp_t;

  typedef struct packed {
    logic        grant;
    logic        rel;
    logic        fail;
    logic [2:0]  sel;
    logic [31:0] now;
    logic [15:0] retry;
    logic [3:0]  pool;
  } cmd_t;

  typedef struct packed {
    logic        vld;
    logic        found;
    logic [2:0]  idx;
    logic [15:0] usage;
  } best_t;

endpackage

`default_nettype wire

@@ hdl/least_used_backend_selector_top.sv @@
// Least-used backend selector.
// A request enters on the in_ channel (in_valid, in_stall, in_req) and carries an
// opcode: acquire, release or fail. Each request gives exactly one response on the
// out_ channel (out_valid, out_stall, out_rsp), in request order.
// One request is handled at a time; in_stall is high from acceptance until the
// response has been taken. An acquire walks a token down a row of HOSTS host cells,
// one cell per cycle, then grants the winner and reads back its count (S_START,
// S_SCAN, S_GRANT, S_RESP, S_OUT), or answers no-host if none is free. A release
// or fail goes via S_EXEC and S_RESP, or to S_OUT with status range if out of pool.
// The walk through the cell row sets the acquire rate.
// While out_stall is high the response is held stable and no new request is taken.
// The cfg_ port writes host_count (index 0) and retry_seconds (index 1) and must be
// used only while no request is in flight.
// Synchronous reset clears every host to enabled with a count of zero and loads
// host_count 1 and retry_seconds 60.
`default_nettype none

module least_used_backend_selector_top
  import lubs_pkg::*;
#(
  parameter int HOSTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output rsp_t             out_rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int         LIM  = (HOSTS < INDEX_LIMIT) ? HOSTS : INDEX_LIMIT;
  localparam logic [3:0] LIM4 = 4'(LIM);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_GRANT, S_EXEC, S_RESP, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  req_t        req_r, req_nxt;
  logic [2:0]  sel_r, sel_nxt;
  rsp_t        rsp_r, rsp_nxt;
  logic [3:0]  host_count_r;
  logic [15:0] retry_r;

  logic [3:0]  pool;
  cmd_t        cmd;
  best_t       chain [HOSTS+1];
  logic [15:0] usage_w [HOSTS];
  logic [15:0] usage_sel;

  assign pool = (host_count_r > LIM4) ? LIM4 : host_count_r;

  always_comb begin
    cmd.grant = state_r == S_GRANT;
    cmd.rel   = (state_r == S_EXEC) && (req_r.opcode == OP_RELEASE);
    cmd.fail  = (state_r == S_EXEC) && (req_r.opcode == OP_FAIL);
    cmd.sel   = sel_r;
    cmd.now   = req_r.now;
    cmd.retry = retry_r;
    cmd.pool  = pool;
  end

  assign chain[0] = '{vld: (state_r == S_START), default: '0};

  for (genvar g = 0; g < HOSTS; g++) begin : g_cell
    lubs_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .best_i  (chain[g]),
      .best_o  (chain[g+1]),
      .usage_o (usage_w[g])
    );
  end

  always_comb begin
    usage_sel = 16'd0;
    for (int i = 0; i < HOSTS; i++) begin
      if (i == int'(sel_r)) begin
        usage_sel = usage_w[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    sel_nxt   = sel_r;
    rsp_nxt   = rsp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          sel_nxt = in_req.host_index;
          if (in_req.opcode == OP_ACQUIRE) begin
            state_nxt = S_START;
          end else if ({1'b0, in_req.host_index} >= pool) begin
            rsp_nxt.status       = (in_req.opcode == OP_RELEASE ||
                                    in_req.opcode == OP_FAIL) ? ST_RANGE : ST_OK;
            rsp_nxt.chosen_index = in_req.host_index;
            rsp_nxt.usage_after  = 16'd0;
            state_nxt            = S_OUT;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_START: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (chain[HOSTS].vld) begin
          if (chain[HOSTS].found) begin
            sel_nxt   = chain[HOSTS].idx;
            state_nxt = S_GRANT;
          end else begin
            rsp_nxt.status       = ST_NO_HOST;
            rsp_nxt.chosen_index = 3'd0;
            rsp_nxt.usage_after  = 16'd0;
            state_nxt            = S_OUT;
          end
        end
      end
      S_GRANT: begin
        state_nxt = S_RESP;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        rsp_nxt.status       = ST_OK;
        rsp_nxt.chosen_index = sel_r;
        rsp_nxt.usage_after  = usage_sel;
        state_nxt            = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    req_r <= req_nxt;
    sel_r <= sel_nxt;
    rsp_r <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_count_r <= HOST_COUNT_RESET;
      retry_r      <= RETRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOST_COUNT: host_count_r <= cfg_wdata[3:0];
        REG_RETRY:      retry_r      <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_rsp   = rsp_r;

endmodule

`default_nettype wire

@@ hdl/lubs_cell.sv @@
`default_nettype none

module lubs_cell
  import lubs_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cmd_t  cmd,
  input  wire best_t best_i,
  output best_t      best_o,
  output logic [15:0] usage_o
);

  localparam logic [2:0] IDX3 = 3'(IDX);

  logic [15:0] usage_r, usage_nxt;
  logic        dis_r, dis_nxt;
  logic [31:0] time_r, time_nxt;
  best_t       best_r, best_nxt;

  logic        active, hit, reen, en, take;
  logic [31:0] elapsed;
  logic [15:0] cur;

  always_comb begin
    active  = IDX < int'(cmd.pool);
    hit     = active && (IDX == int'(cmd.sel));
    elapsed = cmd.now - time_r;
    reen    = best_i.vld && active && dis_r && (elapsed > {16'd0, cmd.retry});
    en      = !dis_r || reen;
    cur     = reen ? 16'd0 : usage_r;
    take    = best_i.vld && active && en && (!best_i.found || cur < best_i.usage);

    best_nxt = best_i;
    if (take) begin
      best_nxt.found = 1'b1;
      best_nxt.idx   = IDX3;
      best_nxt.usage = cur;
    end

    usage_nxt = usage_r;
    dis_nxt   = dis_r;
    time_nxt  = time_r;
    if (reen) begin
      dis_nxt   = 1'b0;
      usage_nxt = 16'd0;
    end
    if (cmd.grant && hit && usage_r != USAGE_MAX) begin
      usage_nxt = usage_r + 16'd1;
    end
    if (cmd.rel && hit && !dis_r && usage_r != 16'd0) begin
      usage_nxt = usage_r - 16'd1;
    end
    if (cmd.fail && hit) begin
      dis_nxt   = 1'b1;
      usage_nxt = 16'd0;
      time_nxt  = cmd.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usage_r    <= 16'd0;
      dis_r      <= 1'b0;
      time_r     <= 32'd0;
      best_r     <= '0;
    end else begin
      usage_r    <= usage_nxt;
      dis_r      <= dis_nxt;
      time_r     <= time_nxt;
      best_r     <= best_nxt;
    end
  end

  assign best_o  = best_r;
  assign usage_o = usage_r;

endmodule

`default_nettype wire

@@ bench/tb_least_used_backend_selector_top.sv @@
`timescale 1ns / 100ps

module tb_least_used_backend_selector_top;
  import lubs_pkg::*;

  localparam int POOL_HOSTS = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CFG_SETTLE = POOL_HOSTS + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_WAIT = 16;

  class host_pool_scoreboard;
    logic [15:0] use_count [POOL_HOSTS];
    bit          down [POOL_HOSTS];
    logic [31:0] down_since [POOL_HOSTS];
    logic [3:0]  pool_cfg;
    logic [15:0] retry_cfg;
    rsp_t        awaited_rsp [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < POOL_HOSTS; i++) begin
        use_count[i] = '0;
        down[i] = 1'b0;
        down_since[i] = '0;
      end
      pool_cfg = HOST_COUNT_RESET;
      retry_cfg = RETRY_RESET;
      mismatches = 0;
    endfunction

    function void write_config(logic idx, logic [15:0] val);
      if (idx == REG_HOST_COUNT) begin
        pool_cfg = val[3:0];
      end else if (idx == REG_RETRY) begin
        retry_cfg = val;
      end
    endfunction

    function rsp_t pool_response(req_t r);
      rsp_t rsp;
      int n;
      int i;
      bit found;
      logic [2:0] best;
      logic [15:0] best_use;
      logic [31:0] elapsed;
      n = (pool_cfg > POOL_HOSTS) ? POOL_HOSTS : int'(pool_cfg);
      rsp.status = ST_OK;
      rsp.chosen_index = r.host_index;
      rsp.usage_after = '0;
      if (r.opcode == OP_ACQUIRE) begin
        found = 1'b0;
        best = '0;
        best_use = '0;
        for (i = 0; i < n; i++) begin
          elapsed = r.now - down_since[i];
          if (down[i] && elapsed > {16'd0, retry_cfg}) begin
            down[i] = 1'b0;
            use_count[i] = '0;
          end
          if (!down[i] && (!found || use_count[i] < best_use)) begin
            found = 1'b1;
            best = i[2:0];
            best_use = use_count[i];
          end
        end
        if (!found) begin
          rsp.status = ST_NO_HOST;
          rsp.chosen_index = '0;
        end else begin
          if (use_count[best] < USAGE_MAX) use_count[best] = use_count[best] + 16'd1;
          rsp.chosen_index = best;
          rsp.usage_after = use_count[best];
        end
      end else if (int'(r.host_index) >= n) begin
        if (r.opcode == OP_RELEASE || r.opcode == OP_FAIL) rsp.status = ST_RANGE;
      end else begin
        if (r.opcode == OP_RELEASE) begin
          if (!down[r.host_index] && use_count[r.host_index] > 0)
            use_count[r.host_index] = use_count[r.host_index] - 16'd1;
        end else if (r.opcode == OP_FAIL) begin
          down[r.host_index] = 1'b1;
          use_count[r.host_index] = '0;
          down_since[r.host_index] = r.now;
        end
        rsp.usage_after = use_count[r.host_index];
      end
      return rsp;
    endfunction

    function void note_request(req_t r);
      awaited_rsp.push_back(pool_response(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected response status %0d host %0d usage %0d", $realtime,
                   got.status, got.chosen_index, got.usage_after);
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status || got.chosen_index !== want.chosen_index ||
          got.usage_after !== want.usage_after) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status %0d host %0d usage %0d, got %0d %0d %0d",
                   $realtime, want.status, want.chosen_index, want.usage_after,
                   got.status, got.chosen_index, got.usage_after);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_rsp;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  host_pool_scoreboard sb;
  bit          idle_on = 1'b1;
  logic [31:0] clock_now = 32'hFFFF_FF00;
  int          quiet = 0;

  least_used_backend_selector_top #(.HOSTS(POOL_HOSTS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [2:0] idx,
                              input logic [31:0] stamp);
    req_t r;
    int gap;
    r.opcode = op;
    r.host_index = idx;
    r.now = stamp;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_config(idx, val);
  endtask

  task automatic run_phase(input logic [3:0] hosts, input logic [15:0] retry, input int count);
    int n;
    int k;
    int pick;
    logic [1:0] op;
    logic [2:0] idx;
    logic [31:0] stamp;
    write_reg(REG_HOST_COUNT, {12'd0, hosts});
    write_reg(REG_RETRY, retry);
    n = (hosts > POOL_HOSTS) ? POOL_HOSTS : int'(hosts);
    for (k = 0; k < count; k++) begin
      if (k % 97 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) op = OP_ACQUIRE;
      else if (pick < 82) op = OP_RELEASE;
      else if (pick < 96) op = OP_FAIL;
      else op = OP_UNUSED;
      if (n > 0 && $urandom_range(0, 9) != 0) idx = 3'($urandom_range(0, n - 1));
      else idx = 3'($urandom_range(0, POOL_HOSTS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        clock_now = clock_now + $urandom_range(0, 3);
        stamp = clock_now;
      end else if (pick < 95) begin
        clock_now = clock_now + $urandom_range(0, 2 * retry + 2);
        stamp = clock_now;
      end else begin
        stamp = $urandom;
      end
      send_request(op, idx, stamp);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb_least_used_backend_selector_top: FAIL");
        $finish;
      end
    end
  end

  initial begin : response_side
    int hold;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_response(out_rsp);
    end
  end

  initial begin : stimulus
    int k;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_ACQUIRE, 3'd0, 32'd0);
    send_request(OP_RELEASE, 3'd3, 32'd0);
    send_request(OP_FAIL, 3'd7, 32'd0);
    send_request(OP_UNUSED, 3'd5, 32'd0);

    write_reg(REG_HOST_COUNT, 16'd8);
    write_reg(REG_RETRY, 16'd0);
    send_request(OP_ACQUIRE, 3'd0, 32'd10);
    send_request(OP_ACQUIRE, 3'd7, 32'd10);
    send_request(OP_ACQUIRE, 3'd0, 32'd10);
    send_request(OP_RELEASE, 3'd1, 32'd10);
    send_request(OP_RELEASE, 3'd1, 32'd10);
    send_request(OP_FAIL, 3'd0, 32'hFFFF_FFF0);
    send_request(OP_FAIL, 3'd0, 32'hFFFF_FFFE);
    send_request(OP_RELEASE, 3'd0, 32'hFFFF_FFFE);
    send_request(OP_UNUSED, 3'd0, 32'hFFFF_FFFE);
    send_request(OP_ACQUIRE, 3'd0, 32'hFFFF_FFFE);
    send_request(OP_ACQUIRE, 3'd0, 32'h0000_0001);

    write_reg(REG_HOST_COUNT, 16'd2);
    send_request(OP_FAIL, 3'd0, 32'd50);
    send_request(OP_FAIL, 3'd1, 32'd50);
    send_request(OP_ACQUIRE, 3'd0, 32'd50);
    send_request(OP_ACQUIRE, 3'd0, 32'd51);
    send_request(OP_RELEASE, 3'd7, 32'd51);

    run_phase(4'd8, 16'd5, 200);
    run_phase(4'd3, 16'd0, 150);
    run_phase(4'd15, 16'hFFFF, 150);
    run_phase(4'd0, 16'd10, 40);
    run_phase(4'd1, 16'd2, 120);
    run_phase(4'd5, 16'd1, 150);
    for (k = 0; k < 3; k++)
      run_phase(4'($urandom_range(1, 15)), 16'($urandom_range(0, 30)), 150);

    in_valid <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_rsp.size() == 0) begin
      $display("tb_least_used_backend_selector_top: PASS");
    end else begin
      $display("tb_least_used_backend_selector_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lubs_pkg.sv
hdl/lubs_cell.sv
hdl/least_used_backend_selector_top.sv
bench/tb_least_used_backend_selector_top.sv
